// ----- src/slt_pkg.sv -----
// slt_pkg: shared types and constants for the sorted list table
// no dependencies; imported by every module of the block

package slt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int MODE_W     = 3;
    localparam int IN_VALUE_W = 32;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int FPOS_W     = 4;
    localparam int COUNT_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REM_POS = 3'd1,
        OP_FIND    = 3'd2,
        OP_REM_VAL = 3'd3,
        OP_COUNT   = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_MISS  = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

endpackage

// ----- src/sorted_list_table_unit.sv -----
// sorted_list_table_unit: ordered table of signed values with a scan sequencer
// depends on slt_pkg and slt_cmp
//
//  channel   | signals                                              | flow
//  ----------+------------------------------------------------------+---------------
//  request   | start, busy, mode, value, position                   | start & !busy
//  result    | done, status, found, found_position, match_count,    | done, 1 cycle
//            | list_length                                          |
//
// clear, full insert and bad positions go straight to the result; scans read
// one stored entry per cycle through the single memory read
// port and the shared comparator. busy is high from acceptance and drops in the cycle
// of the done strobe. rst_n empties the table; stored values are not cleared.
// results cannot be stalled; done is a one-cycle strobe.

module sorted_list_table_unit
    import slt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic signed [IN_VALUE_W-1:0] value,
    input  logic [POS_W-1:0]      position,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic                  found,
    output logic [FPOS_W-1:0]     found_position,
    output logic [COUNT_W-1:0]    match_count,
    output logic [COUNT_W-1:0]    list_length
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rd_data_reg;

    state_t                state_reg, state_next;
    logic [LW-1:0]         length_reg, length_next;
    logic [LW-1:0]         ptr_reg, ptr_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  done_reg, done_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    op_t                   op_reg, op_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  hit_reg, hit_next;
    status_t               status_reg, status_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         fpos_reg, fpos_next;
    logic [LW-1:0]         cnt_reg, cnt_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [LW-1:0]         ptr_dec;
    cmp_t                  cmp;

    slt_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .a   (rd_data_reg),
        .b   (val_reg),
        .res (cmp)
    );

    // entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            length_reg   <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        rd_idx_reg <= rd_idx_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fpos_reg   <= fpos_next;
        cnt_reg    <= cnt_next;
    end

    assign ptr_dec = ptr_reg - LW'(1);

    always_comb
    begin
        state_next    = state_reg;
        length_next   = length_reg;
        ptr_next      = ptr_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        val_next      = val_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        fpos_next     = fpos_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = val_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_t'(mode);
                    val_next    = VALUE_BITS'(value);
                    hit_next    = 1'b0;
                    status_next = STS_OK;
                    found_next  = 1'b0;
                    fpos_next   = '0;
                    cnt_next    = '0;
                    ptr_next    = '0;
                    unique case (op_t'(mode)) inside
                        OP_INSERT:
                        begin
                            if (length_reg == LW'(CAPACITY))
                            begin
                                status_next = STS_FULL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                ptr_next   = length_reg;
                                state_next = ST_DOWN;
                            end
                        end
                        OP_REM_POS:
                        begin
                            if (length_reg == '0)
                            begin
                                status_next = STS_MISS;
                                state_next  = ST_DONE;
                            end
                            else if (CMPW'(position) >= CMPW'(length_reg))
                            begin
                                status_next = STS_RANGE;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                hit_next   = 1'b1;
                                ptr_next   = LW'(position) + LW'(1);
                                state_next = ST_UP;
                            end
                        end
                        OP_FIND, OP_REM_VAL:
                        begin
                            status_next = STS_MISS;
                            state_next  = ST_UP;
                        end
                        OP_COUNT:
                        begin
                            state_next = ST_UP;
                        end
                        OP_CLEAR:
                        begin
                            length_next = '0;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // ascending walk: find, count, remove
            ST_UP:
            begin
                if (ptr_reg < length_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + LW'(1);
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_DONE;
                end

                if (rd_valid_reg)
                begin
                    case (op_reg) inside
                        OP_FIND:
                        begin
                            if (cmp.eq)
                            begin
                                found_next  = 1'b1;
                                fpos_next   = rd_idx_reg;
                                status_next = STS_OK;
                                state_next  = ST_DONE;
                            end
                        end
                        OP_COUNT:
                        begin
                            if (cmp.eq)
                            begin
                                cnt_next = cnt_reg + LW'(1);
                            end
                        end
                        OP_REM_POS, OP_REM_VAL:
                        begin
                            if (hit_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = rd_idx_reg - AW'(1);
                                wr_data = rd_data_reg;
                            end
                            else if (cmp.eq)
                            begin
                                hit_next    = 1'b1;
                                status_next = STS_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // descending walk: shift larger entries up, drop value into the gap
            ST_DOWN:
            begin
                rd_addr = ptr_dec[AW-1:0];
                if (ptr_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_dec[AW-1:0];
                    ptr_next      = ptr_dec;
                end

                if (rd_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + AW'(1);
                    if (cmp.gt)
                    begin
                        wr_data = rd_data_reg;
                    end
                    else
                    begin
                        wr_data    = val_reg;
                        state_next = ST_DONE;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = val_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_INSERT && status_reg == STS_OK)
                begin
                    length_next = length_reg + LW'(1);
                end
                else if ((op_reg == OP_REM_POS || op_reg == OP_REM_VAL) && hit_reg)
                begin
                    length_next = length_reg - LW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign found_position = FPOS_W'(fpos_reg);
    assign match_count    = COUNT_W'(cnt_reg);
    assign list_length    = COUNT_W'(length_reg);

endmodule

// ----- src/slt_cmp.sv -----
// slt_cmp: two's complement signed compare shared by every scan of the table
// depends on slt_pkg (cmp_t)

module slt_cmp
    import slt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output cmp_t                  res
);

    always_comb
    begin
        res.eq = (a == b);
        res.gt = ($signed(a) > $signed(b));
    end

endmodule

// ----- src/slt_checker.sv -----
// slt_checker: port-level checks of the request and result timing
// depends on slt_pkg; bound to sorted_list_table_unit

module slt_checker
    import slt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic                found
);

    // a result is never shown while a request is still in flight
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // every request ends with exactly one result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == STS_OK))
        else $error("found reported with error status");

endmodule

bind sorted_list_table_unit slt_checker u_slt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .found  (found)
);
